// ===== sv/gpp_pkg.sv =====
// Ground plane point projection: shared types and constants.
// Register map codes, fixed-point limits, overview map constants.
// No dependencies.
package gpp_pkg;

  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_PLANE_A    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PLANE_B    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PLANE_C    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PLANE_D    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_COL = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_ROW = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_FOCAL_LEN  = 3'd6;

  localparam logic signed [31:0] RST_PLANE_A    = -32'sd2359;
  localparam logic signed [31:0] RST_PLANE_B    = 32'sd648806;
  localparam logic signed [31:0] RST_PLANE_C    = 32'sd160563;
  localparam logic signed [31:0] RST_PLANE_D    = -32'sd981205;
  localparam logic [15:0]        RST_CENTER_COL = 16'd14968;
  localparam logic [15:0]        RST_CENTER_ROW = 16'd8285;
  localparam logic [15:0]        RST_FOCAL_LEN  = 16'd18624;

  localparam int FRAC_BITS = 16;
  localparam int INT_BITS  = 7;
  localparam int QUO_BITS  = FRAC_BITS + INT_BITS;
  localparam int DIV_LAT   = QUO_BITS + 1;
  localparam int XZ_W      = QUO_BITS + 1;

  localparam logic [XZ_W-1:0] SAT_MAG = XZ_W'(1) << QUO_BITS;
  localparam logic [XZ_W-1:0] SAT_POS = SAT_MAG - XZ_W'(1);
  localparam logic [XZ_W-1:0] LIM_X_Q = XZ_W'(10) << FRAC_BITS;
  localparam logic [XZ_W-1:0] LIM_Z_Q = XZ_W'(20) << FRAC_BITS;

  localparam int MAP_W      = 34;
  localparam int MAP_PIX_W  = 12;
  localparam logic signed [MAP_W-1:0] MAP_COL0_Q = MAP_W'(1682) <<< FRAC_BITS;
  localparam logic signed [MAP_W-1:0] MAP_ROW0_Q = MAP_W'(515) <<< FRAC_BITS;
  localparam logic signed [MAP_W-1:0] MAP_SCALE  = MAP_W'(23);

  typedef struct packed {
    logic valid;
    logic zero;
    logic neg_z;
    logic neg_x;
  } gpp_side_t;

  typedef struct packed {
    logic                 in_range;
    logic [MAP_PIX_W-1:0] map_col;
    logic [MAP_PIX_W-1:0] map_row;
    logic [XZ_W-1:0]      depth_z;
    logic [XZ_W-1:0]      lateral_x;
  } gpp_result_t;

endpackage

// ===== sv/ground_plane_point_projection_core.sv =====
// Structure: the pipeline has 31 register stages (four front stages, a 24-stage
// bit-per-stage divider, two back stages, one output register), the first loaded
// at the accepting edge of an input transaction.
// Throughput: one transaction per cycle while the skid entry is empty; a full skid entry stalls the pipeline.
// Reset: rst_n synchronous, active low; clears all valid bits and loads the
// plane, principal point and focal length registers with their defaults.
module ground_plane_point_projection_core #(
  parameter int PIXEL_BITS = 12
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [4:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [PIXEL_BITS-1:0]         in_box_left,
  input  logic [PIXEL_BITS-1:0]         in_box_right,
  input  logic [PIXEL_BITS-1:0]         in_box_bottom,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_in_range,
  output logic [gpp_pkg::MAP_PIX_W-1:0] out_map_col,
  output logic [gpp_pkg::MAP_PIX_W-1:0] out_map_row,
  output logic signed [gpp_pkg::XZ_W-1:0] out_depth_z,
  output logic signed [gpp_pkg::XZ_W-1:0] out_lateral_x
);
  import gpp_pkg::*;

  localparam int OFF_W  = PIXEL_BITS + 4;
  localparam int DX_W   = (OFF_W > 16 ? OFF_W : 16) + 1;
  localparam int MAG_W  = DX_W - 1;
  localparam int PA_W   = 32 + DX_W;
  localparam int PC_W   = 32 + 17;
  localparam int DEN_W  = (PA_W > PC_W ? PA_W : PC_W) + 2;
  localparam int NUMX_W = 32 + MAG_W;
  localparam int NUM_W  = NUMX_W > 48 ? NUMX_W : 48;

  // configuration registers
  logic signed [31:0] plane_a_r, plane_b_r, plane_c_r, plane_d_r;
  logic [15:0]        center_col_r, center_row_r, focal_len_r;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic               cfg_wr;

  assign cfg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plane_a_r    <= RST_PLANE_A;
      plane_b_r    <= RST_PLANE_B;
      plane_c_r    <= RST_PLANE_C;
      plane_d_r    <= RST_PLANE_D;
      center_col_r <= RST_CENTER_COL;
      center_row_r <= RST_CENTER_ROW;
      focal_len_r  <= RST_FOCAL_LEN;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_PLANE_A:    plane_a_r    <= pwdata;
        REG_PLANE_B:    plane_b_r    <= pwdata;
        REG_PLANE_C:    plane_c_r    <= pwdata;
        REG_PLANE_D:    plane_d_r    <= pwdata;
        REG_CENTER_COL: center_col_r <= pwdata[15:0];
        REG_CENTER_ROW: center_row_r <= pwdata[15:0];
        REG_FOCAL_LEN:  focal_len_r  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_PLANE_A:    prdata = plane_a_r;
      REG_PLANE_B:    prdata = plane_b_r;
      REG_PLANE_C:    prdata = plane_c_r;
      REG_PLANE_D:    prdata = plane_d_r;
      REG_CENTER_COL: prdata = 32'(center_col_r);
      REG_CENTER_ROW: prdata = 32'(center_row_r);
      REG_FOCAL_LEN:  prdata = 32'(focal_len_r);
      default:        prdata = '0;
    endcase
  end

  // pipeline advance and output buffering
  logic        en;
  logic        sk_v_r, ov_r;
  gpp_result_t sk_r, ov_data_r;

  assign en       = !sk_v_r;
  assign in_ready = en;

  // stage 1: offsets from principal point
  logic                   v1_r;
  logic signed [DX_W-1:0] dx_r, dy_r;
  logic [PIXEL_BITS:0]    sum_lr;
  logic [OFF_W-1:0]       col16, row16;

  assign sum_lr = {1'b0, in_box_left} + {1'b0, in_box_right};
  assign col16  = {sum_lr[PIXEL_BITS:1], 4'b0000};
  assign row16  = {in_box_bottom, 4'b0000};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dx_r <= $signed(DX_W'(col16)) - $signed(DX_W'(center_col_r));
      dy_r <= $signed(DX_W'(row16)) - $signed(DX_W'(center_row_r));
    end
  end

  // stage 2: plane products
  logic                   v2_r;
  logic signed [PA_W-1:0] pa_r, pb_r;
  logic signed [PC_W-1:0] pc_r;
  logic [MAG_W-1:0]       dxm_r;
  logic                   dxn_r;
  logic [DX_W-1:0]        dx_abs;

  assign dx_abs = dx_r[DX_W-1] ? DX_W'(-dx_r) : DX_W'(dx_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pa_r  <= PA_W'(plane_a_r) * PA_W'(dx_r);
      pb_r  <= PA_W'(plane_b_r) * PA_W'(dy_r);
      pc_r  <= PC_W'(plane_c_r) * $signed(PC_W'(focal_len_r));
      dxm_r <= dx_abs[MAG_W-1:0];
      dxn_r <= dx_r[DX_W-1];
    end
  end

  // stage 3: denominator and numerators
  logic                    v3_r;
  logic signed [DEN_W-1:0] den_r;
  logic [NUM_W-1:0]        numx_r, numz_r;
  logic                    dxn3_r;
  logic [31:0]             d_abs;

  assign d_abs = plane_d_r[31] ? 32'(-plane_d_r) : 32'(plane_d_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      den_r  <= DEN_W'(pa_r) + DEN_W'(pb_r) + DEN_W'(pc_r);
      numx_r <= NUM_W'(d_abs) * NUM_W'(dxm_r);
      numz_r <= NUM_W'(d_abs) * NUM_W'(focal_len_r);
      dxn3_r <= dxn_r;
    end
  end

  // stage 4: magnitude and signs
  logic             v4_r, zero4_r, negz4_r, negx4_r;
  logic [DEN_W-1:0] nm4_r;
  logic [NUM_W-1:0] numx4_r, numz4_r;
  logic             negz;

  assign negz = (plane_d_r > 0) != den_r[DEN_W-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (en) begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nm4_r   <= den_r[DEN_W-1] ? DEN_W'(-den_r) : DEN_W'(den_r);
      zero4_r <= (den_r == '0) || (focal_len_r == '0);
      negz4_r <= negz;
      negx4_r <= negz != dxn3_r;
      numx4_r <= numx_r;
      numz4_r <= numz_r;
    end
  end

  // dividers with matching sideband line
  logic [QUO_BITS-1:0] qz, qx;
  logic                satz, satx;
  gpp_side_t           side_r [DIV_LAT];

  gpp_div_pipe #(.NUM_W(NUM_W), .DEN_W(DEN_W)) u_div_z (
    .clk (clk), .en (en), .num (numz4_r), .den (nm4_r), .quo (qz), .sat (satz)
  );

  gpp_div_pipe #(.NUM_W(NUM_W), .DEN_W(DEN_W)) u_div_x (
    .clk (clk), .en (en), .num (numx4_r), .den (nm4_r), .quo (qx), .sat (satx)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < DIV_LAT; k++) begin
        side_r[k] <= '0;
      end
    end else if (en) begin
      side_r[0] <= '{valid: v4_r, zero: zero4_r, neg_z: negz4_r, neg_x: negx4_r};
      for (int k = 1; k < DIV_LAT; k++) begin
        side_r[k] <= side_r[k-1];
      end
    end
  end

  // stage 5: sign, saturation, range
  gpp_side_t        side_o;
  logic [XZ_W-1:0]  mz, mx, zq, xq;
  logic             v5_r, zero5_r, rng5_r;
  logic [XZ_W-1:0]  zq5_r, xq5_r;

  assign side_o = side_r[DIV_LAT-1];
  assign mz     = satz ? SAT_MAG : {1'b0, qz};
  assign mx     = satx ? SAT_MAG : {1'b0, qx};
  assign zq     = side_o.neg_z ? XZ_W'(-mz) : (mz >= SAT_MAG ? SAT_POS : mz);
  assign xq     = side_o.neg_x ? XZ_W'(-mx) : (mx >= SAT_MAG ? SAT_POS : mx);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else if (en) begin
      v5_r <= side_o.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      zero5_r <= side_o.zero;
      rng5_r  <= (mx < LIM_X_Q) && (mz < LIM_Z_Q);
      zq5_r   <= zq;
      xq5_r   <= xq;
    end
  end

  // stage 6: overview map coordinates
  logic signed [MAP_W-1:0] map_c, map_w;
  logic                    v6_r;
  gpp_result_t             res6_r;

  assign map_c = MAP_COL0_Q + MAP_W'($signed(xq5_r)) * MAP_SCALE;
  assign map_w = MAP_ROW0_Q - MAP_W'($signed(zq5_r)) * MAP_SCALE;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v6_r <= 1'b0;
    end else if (en) begin
      v6_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (zero5_r) begin
        res6_r <= '0;
      end else begin
        res6_r.in_range  <= rng5_r;
        res6_r.map_col   <= rng5_r ? map_c[FRAC_BITS +: MAP_PIX_W] : '0;
        res6_r.map_row   <= rng5_r ? map_w[FRAC_BITS +: MAP_PIX_W] : '0;
        res6_r.depth_z   <= zq5_r;
        res6_r.lateral_x <= xq5_r;
      end
    end
  end

  // output register with skid entry
  logic take, leaving;

  assign take    = ov_r && out_ready;
  assign leaving = v6_r && en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r   <= 1'b0;
      sk_v_r <= 1'b0;
    end else if (sk_v_r) begin
      if (take || !ov_r) begin
        ov_r   <= 1'b1;
        sk_v_r <= 1'b0;
      end
    end else if (!ov_r || take) begin
      ov_r <= leaving;
    end else if (leaving) begin
      sk_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (sk_v_r) begin
      if (take || !ov_r) begin
        ov_data_r <= sk_r;
      end
    end else if (!ov_r || take) begin
      ov_data_r <= res6_r;
    end else if (leaving) begin
      sk_r <= res6_r;
    end
  end

  assign out_valid     = ov_r;
  assign out_in_range  = ov_data_r.in_range;
  assign out_map_col   = ov_data_r.map_col;
  assign out_map_row   = ov_data_r.map_row;
  assign out_depth_z   = ov_data_r.depth_z;
  assign out_lateral_x = ov_data_r.lateral_x;

`ifndef ASSERT_OFF
  a_skid_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
    sk_v_r |-> ov_r) else $error("skid entry held without output entry");

  a_skid_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && !out_ready && leaving) |=> sk_v_r)
    else $error("stalled transaction not captured in skid entry");

  a_skid_rise: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(sk_v_r) |-> $past(ov_r && !out_ready))
    else $error("skid entry filled without output stall");

  a_map_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_in_range) |-> (out_map_col == '0 && out_map_row == '0))
    else $error("map coordinates nonzero for point out of range");
`endif

endmodule

// ===== sv/gpp_div_pipe.sv =====
// Pipelined restoring divider: trunc(num * 2^16 / den), one quotient bit per stage.
// Flags saturation when the quotient reaches 128. Depends on gpp_pkg.
module gpp_div_pipe #(
  parameter int NUM_W = 53,
  parameter int DEN_W = 56
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic [NUM_W-1:0]              num,
  input  logic [DEN_W-1:0]              den,
  output logic [gpp_pkg::QUO_BITS-1:0]  quo,
  output logic                          sat
);
  import gpp_pkg::*;

  localparam int TOP_W = NUM_W - INT_BITS;
  localparam int CMP_W = (TOP_W > DEN_W ? TOP_W : DEN_W) + 1;

  logic [DEN_W-1:0]    rem_r [QUO_BITS];
  logic [DEN_W-1:0]    den_r [QUO_BITS];
  logic [QUO_BITS-1:0] ext_r [QUO_BITS];
  logic [QUO_BITS-1:0] q_r   [QUO_BITS+1];
  logic                sat_r [QUO_BITS+1];

  logic [CMP_W-1:0] top_ext;
  logic [CMP_W-1:0] den_ext;

  assign top_ext = CMP_W'(num[NUM_W-1:INT_BITS]);
  assign den_ext = CMP_W'(den);

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= DEN_W'(num[NUM_W-1:INT_BITS]);
      den_r[0] <= den;
      ext_r[0] <= {num[INT_BITS-1:0], FRAC_BITS'(0)};
      q_r[0]   <= '0;
      sat_r[0] <= (top_ext >= den_ext);
    end
  end

  for (genvar k = 1; k <= QUO_BITS; k++) begin : g_step
    logic [DEN_W:0] trial;
    logic [DEN_W:0] diff;
    logic           fits;

    assign trial = {rem_r[k-1], ext_r[k-1][QUO_BITS-1]};
    assign diff  = trial - {1'b0, den_r[k-1]};
    assign fits  = (trial >= {1'b0, den_r[k-1]});

    always_ff @(posedge clk) begin
      if (en) begin
        q_r[k]   <= {q_r[k-1][QUO_BITS-2:0], fits};
        sat_r[k] <= sat_r[k-1];
      end
    end

    if (k < QUO_BITS) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[k] <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
          den_r[k] <= den_r[k-1];
          ext_r[k] <= ext_r[k-1] << 1;
        end
      end
    end
  end

  assign quo = q_r[QUO_BITS];
  assign sat = sat_r[QUO_BITS];

endmodule
